[sv/gsps_pkg.sv]
// ----------------------------------------------------------------------------
// gsps_pkg: shared types and constants of the PD steering controller
// Holds the sequencer states, the multiply operation codes, register indexes,
// gain set codes and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsps_pkg;

  localparam int unsigned GAIN_W   = 16;  // Q4.12 gain
  localparam int unsigned MPLIER_W = 17;  // widest serial multiplier operand
  localparam int unsigned PROD_W   = GAIN_W + MPLIER_W + 1;
  localparam int unsigned ACC_W    = 34;
  localparam int unsigned ERR_W    = 9;
  localparam int unsigned DER_W    = 10;
  localparam int unsigned DRIVE_W  = 32;
  localparam int unsigned SET_W    = 3;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned IDX_W    = 3;

  localparam logic [ERR_W-1:0] ERROR_CENTRE = 9'd56;
  localparam logic [3:0] RING_PHASE_LOW  = 4'd5;
  localparam logic [3:0] RING_PHASE_HIGH = 4'd8;
  localparam logic [1:0] RING_COUNT_ONE  = 2'd1;
  localparam logic [1:0] RING_COUNT_TWO  = 2'd2;

  // Gain set codes reported with each result.
  localparam logic [SET_W-1:0] SET_NORMAL     = 3'd0;
  localparam logic [SET_W-1:0] SET_RING1_FIRST = 3'd1;
  localparam logic [SET_W-1:0] SET_RING1_LATER = 3'd2;
  localparam logic [SET_W-1:0] SET_RING2_FIRST = 3'd3;
  localparam logic [SET_W-1:0] SET_RING2_LATER = 3'd4;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_NORMAL_GAINS     = 3'd0;
  localparam logic [IDX_W-1:0] REG_QUADRATIC_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RING_ONE_FIRST   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RING_ONE_LATER   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RING_TWO_FIRST   = 3'd4;
  localparam logic [IDX_W-1:0] REG_RING_TWO_LATER   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } gsps_state_t;

  typedef enum logic [1:0] {
    OP_SQUARE,  // error * |error|
    OP_QUAD,    // quadratic gain term
    OP_PROP,    // proportional term
    OP_DERIV    // derivative term
  } gsps_op_t;

  typedef struct packed {
    logic                       start;
    logic signed [GAIN_W-1:0]   mcand;
    logic signed [MPLIER_W-1:0] mplier;
  } gsps_mul_req_t;

  typedef struct packed {
    logic                     done;
    logic                     busy;
    logic signed [PROD_W-1:0] product;
  } gsps_mul_rsp_t;

endpackage

`default_nettype wire

[sv/gain_scheduled_pd_steering.sv]
// ----------------------------------------------------------------------------
// gain_scheduled_pd_steering: PD steering controller with gain scheduling
// Forms error and derivative of the track position and drives
// Kp*e + Kq*e*|e| + Kd*de through one bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transfer per camera frame, position in tdata,
//   roundabout phase, ring count and first-ring flag in tuser.
//   Output stream (m_axis): one transfer per input, the saturated steering
//   command in tdata and the gain set that was used in tuser.
//   Configuration: write cfg_data to register cfg_index while cfg_write is
//   high; indexes above five are ignored. Write only while the block is idle.
// Timing:
//   Four serial multiplications (e*|e|, then Kq, Kp and Kd terms), each of
//   17 shift steps and a done strobe, run back to back on the shared
//   multiplier; the sum is then registered in the output register, and only
//   after that does the block take a new input, so it does not accept a new
//   item before it is through with the last one.
//   The finished result sits in an output register; if the receiver stalls,
//   the block holds the next finished result until that register frees.
// Reset: rst clears the configuration registers, the state, the stored error
//   and the output valid, and holds s_axis_tready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gain_scheduled_pd_steering (
  input  wire        clk,
  input  wire        rst,
  // configuration write port
  input  wire        cfg_write,
  input  wire [2:0]  cfg_index,
  input  wire [31:0] cfg_data,
  // input stream
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [7:0]  s_axis_tdata,   // [7:0] position
  input  wire [6:0]  s_axis_tuser,   // [3:0] ring_phase, [5:4] ring_count, [6] first_ring
  // output stream
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] drive
  output logic [2:0]  m_axis_tuser   // [2:0] gain_set
);
  import gsps_pkg::*;

  // configuration registers
  logic [31:0]       normal_gains;
  logic [GAIN_W-1:0] quadratic_gain;
  logic [31:0]       ring_one_first_gains;
  logic [31:0]       ring_one_later_gains;
  logic [31:0]       ring_two_first_gains;
  logic [31:0]       ring_two_later_gains;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_gains         <= '0;
      quadratic_gain       <= '0;
      ring_one_first_gains <= '0;
      ring_one_later_gains <= '0;
      ring_two_first_gains <= '0;
      ring_two_later_gains <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NORMAL_GAINS:   normal_gains         <= cfg_data;
        REG_QUADRATIC_GAIN: quadratic_gain       <= cfg_data[GAIN_W-1:0];
        REG_RING_ONE_FIRST: ring_one_first_gains <= cfg_data;
        REG_RING_ONE_LATER: ring_one_later_gains <= cfg_data;
        REG_RING_TWO_FIRST: ring_two_first_gains <= cfg_data;
        REG_RING_TWO_LATER: ring_two_later_gains <= cfg_data;
        default: ;
      endcase
    end
  end

  // gain selection and error forming on the incoming item
  logic [3:0]              in_phase;
  logic [1:0]              in_count;
  logic                    in_first;
  logic                    ring_en;
  logic [SET_W-1:0]        in_set;
  logic [31:0]             in_gains;
  logic signed [ERR_W-1:0] in_err;
  logic signed [ERR_W-1:0] in_abs;
  logic signed [DER_W-1:0] in_der;

  assign in_phase = s_axis_tuser[3:0];
  assign in_count = s_axis_tuser[5:4];
  assign in_first = s_axis_tuser[6];
  assign ring_en  = (in_phase >= RING_PHASE_LOW) && (in_phase <= RING_PHASE_HIGH);

  // state
  gsps_state_t             state, state_next;
  gsps_op_t                op, op_next;
  logic signed [ERR_W-1:0] prev_err, prev_err_next;
  logic signed [ERR_W-1:0] err, err_next;
  logic signed [DER_W-1:0] der, der_next;
  logic [GAIN_W-1:0]       kp, kp_next;
  logic [GAIN_W-1:0]       kd, kd_next;
  logic [SET_W-1:0]        set_code, set_code_next;
  logic signed [ACC_W-1:0] acc, acc_next;
  logic                    out_valid, out_valid_next;
  logic [DRIVE_W-1:0]      out_drive, out_drive_next;
  logic [SET_W-1:0]        out_set, out_set_next;
  logic [DRIVE_W-1:0]      drive_sat;

  gsps_mul_req_t mul_req;
  gsps_mul_rsp_t mul_rsp;

  always_comb begin
    in_set   = SET_NORMAL;
    in_gains = normal_gains;
    if (ring_en && in_count == RING_COUNT_ONE) begin
      in_set   = in_first ? SET_RING1_FIRST : SET_RING1_LATER;
      in_gains = in_first ? ring_one_first_gains : ring_one_later_gains;
    end else if (ring_en && in_count == RING_COUNT_TWO) begin
      in_set   = in_first ? SET_RING2_FIRST : SET_RING2_LATER;
      in_gains = in_first ? ring_two_first_gains : ring_two_later_gains;
    end
    in_err = $signed({1'b0, s_axis_tdata} - ERROR_CENTRE);
    in_abs = in_err[ERR_W-1] ? -in_err : in_err;
    in_der = DER_W'(in_err) - DER_W'(prev_err);
  end

  // The sum always fits 32 bits at these widths; clamp it anyway.
  always_comb begin
    if (acc[ACC_W-1:DRIVE_W-1] == '0 || acc[ACC_W-1:DRIVE_W-1] == '1) begin
      drive_sat = acc[DRIVE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    prev_err_next  = prev_err;
    err_next       = err;
    der_next       = der;
    kp_next        = kp;
    kd_next        = kd;
    set_code_next  = set_code;
    acc_next       = acc;
    out_valid_next = out_valid;
    out_drive_next = out_drive;
    out_set_next   = out_set;
    mul_req        = '0;
    s_axis_tready  = 1'b0;

    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid && !rst) begin
          err_next       = in_err;
          der_next       = in_der;
          prev_err_next  = in_err;
          kp_next        = in_gains[GAIN_W-1:0];
          kd_next        = in_gains[2*GAIN_W-1:GAIN_W];
          set_code_next  = in_set;
          acc_next       = '0;
          op_next        = OP_SQUARE;
          mul_req.start  = 1'b1;
          mul_req.mcand  = GAIN_W'(in_err);
          mul_req.mplier = MPLIER_W'(in_abs);
          state_next     = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          case (op)
            OP_SQUARE: begin
              // e*|e| lies in -3136..39601 and fits the 17-bit operand.
              mul_req.start  = 1'b1;
              mul_req.mcand  = quadratic_gain;
              mul_req.mplier = mul_rsp.product[MPLIER_W-1:0];
              op_next        = OP_QUAD;
            end
            OP_QUAD: begin
              acc_next       = acc + mul_rsp.product;
              mul_req.start  = 1'b1;
              mul_req.mcand  = kp;
              mul_req.mplier = MPLIER_W'(err);
              op_next        = OP_PROP;
            end
            OP_PROP: begin
              acc_next       = acc + mul_rsp.product;
              mul_req.start  = 1'b1;
              mul_req.mcand  = kd;
              mul_req.mplier = MPLIER_W'(der);
              op_next        = OP_DERIV;
            end
            OP_DERIV: begin
              acc_next   = acc + mul_rsp.product;
              state_next = ST_FIN;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FIN: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_drive_next = drive_sat;
          out_set_next   = set_code;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_SQUARE;
      prev_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      prev_err  <= prev_err_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    err       <= err_next;
    der       <= der_next;
    kp        <= kp_next;
    kd        <= kd_next;
    set_code  <= set_code_next;
    acc       <= acc_next;
    out_drive <= out_drive_next;
    out_set   <= out_set_next;
  end

  gsps_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_drive;
  assign m_axis_tuser  = out_set;

  a_done_in_mul : assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == ST_MUL)
    else $error("multiplier finished outside the multiply phase");

  a_mul_free_in_idle : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mul_rsp.busy)
    else $error("multiplier still busy while waiting for input");

  a_prev_err_kept : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> prev_err == $past(in_err))
    else $error("stored error not updated on input transfer");

  a_sum_in_range : assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> (acc[ACC_W-1:DRIVE_W-1] == '0 || acc[ACC_W-1:DRIVE_W-1] == '1))
    else $error("accumulated sum left the 32-bit range");

  a_set_code_valid : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= SET_RING2_LATER)
    else $error("gain set code out of range");

endmodule

`default_nettype wire

[sv/gsps_serial_mul.sv]
// ----------------------------------------------------------------------------
// gsps_serial_mul: bit-serial signed shift-add multiplier
// Multiplies a 16-bit signed operand by a 17-bit signed operand, one
// multiplier bit per cycle, with an 18-bit adder and a right-shifting product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsps_serial_mul (
  input  wire                    clk,
  input  wire                    rst,
  input  wire gsps_pkg::gsps_mul_req_t req,
  output gsps_pkg::gsps_mul_rsp_t rsp
);
  import gsps_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MPLIER_W - 1);

  logic                       busy;
  logic                       done;
  logic [CNT_W-1:0]           cnt;
  logic signed [GAIN_W-1:0]   mcand;
  logic [MPLIER_W-1:0]        hi;
  logic [MPLIER_W-1:0]        lo;

  logic signed [MPLIER_W:0]   hi_ext;
  logic signed [MPLIER_W:0]   addend;
  logic signed [MPLIER_W:0]   sum;

  // The sign bit of the multiplier carries negative weight, so the last
  // step subtracts the multiplicand instead of adding it.
  always_comb begin
    hi_ext = {hi[MPLIER_W-1], hi};
    addend = lo[0] ? (MPLIER_W+1)'(mcand) : '0;
    if (cnt == LAST_STEP) begin
      sum = hi_ext - addend;
    end else begin
      sum = hi_ext + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand <= req.mcand;
      hi    <= '0;
      lo    <= req.mplier;
    end else if (busy) begin
      hi <= sum[MPLIER_W:1];
      lo <= {sum[0], lo[MPLIER_W-1:1]};
    end
  end

  assign rsp.done    = done;
  assign rsp.busy    = busy;
  assign rsp.product = {hi, lo};

  a_start_when_free : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("multiply started while busy");

  a_done_ends_busy : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("multiplier stopped without done");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

`default_nettype wire
